[rtl/mlpq_pkg.sv]
// shared types, codes and default sizes for the multi-level priority fifo
// no dependencies; used by every module of the block
package mlpq_pkg;

	localparam int NUM_LEVELS_DEF  = 8;
	localparam int LEVEL_DEPTH_DEF = 8;
	localparam int DATA_WIDTH_DEF  = 32;

	// request function codes
	localparam logic FUNC_ENQ = 1'b0;
	localparam logic FUNC_DEQ = 1'b1;

	typedef enum logic [1:0] {
		ST_ENQ_OK    = 2'd0,
		ST_ENQ_DROP  = 2'd1,
		ST_DEQ_OK    = 2'd2,
		ST_DEQ_EMPTY = 2'd3
	} status_t;

	typedef struct packed {
		logic        func;
		logic [2:0]  priority_req;
		logic [31:0] data_in;
	} req_t;

	typedef struct packed {
		status_t     status;
		logic [31:0] data_out;
		logic [2:0]  served_level;
	} rsp_t;

	// controller to datapath commands
	typedef struct packed {
		logic capture;
		logic exec;
		logic load;
	} cmd_t;

endpackage

[rtl/multi_level_priority_fifo.sv]
// top level of the strict-priority multi-level fifo
// depends on mlpq_pkg, mlpq_ctrl and mlpq_dp
module multi_level_priority_fifo import mlpq_pkg::*; #(
	parameter int NUM_LEVELS  = NUM_LEVELS_DEF,
	parameter int LEVEL_DEPTH = LEVEL_DEPTH_DEF,
	parameter int DATA_WIDTH  = DATA_WIDTH_DEF
) (
	input  logic clk,
	input  logic arst_n,
	input  logic req_valid,
	output logic req_stall,
	input  req_t req,
	output logic rsp_valid,
	input  logic rsp_stall,
	output rsp_t rsp
);

	// Strict-priority queue with one circular fifo of LEVEL_DEPTH words per
	// level. Each request transfer gives exactly one response transfer: an
	// enqueue appends data_in to the fifo of priority_req (dropped, status 1,
	// when the level is full or out of range), a dequeue pops the oldest word
	// of the lowest-numbered non-empty level (status 3 when all are empty).
	// A request passes through three steps: capture, then level select with
	// pointer update and memory access, then response register load; the
	// single-port entry memory and registered read data keep them apart. A
	// new request is taken once the last is loaded; the response register
	// holds a finished result while the next request is taken and worked on,
	// and the load waits while rsp_stall holds it. No clearing pass is needed
	// after reset: per-level counts gate every memory read.

	cmd_t cmd;

	// sequencing and handshake
	mlpq_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.req_valid (req_valid),
		.req_stall (req_stall),
		.rsp_valid (rsp_valid),
		.rsp_stall (rsp_stall),
		.cmd       (cmd)
	);

	// storage, level select and response payload
	mlpq_dp #(
		.NUM_LEVELS  (NUM_LEVELS),
		.LEVEL_DEPTH (LEVEL_DEPTH),
		.DATA_WIDTH  (DATA_WIDTH)
	) u_dp (
		.clk    (clk),
		.arst_n (arst_n),
		.cmd    (cmd),
		.req    (req),
		.rsp    (rsp)
	);

endmodule

[rtl/mlpq_ctrl.sv]
// sequencing state machine and response handshake for the priority fifo
// depends on mlpq_pkg
module mlpq_ctrl import mlpq_pkg::*; (
	input  logic clk,
	input  logic arst_n,
	input  logic req_valid,
	output logic req_stall,
	output logic rsp_valid,
	input  logic rsp_stall,
	output cmd_t cmd
);

	typedef enum logic [1:0] {
		S_IDLE,
		S_EXEC,
		S_RESP
	} state_t;

	state_t state_q;
	logic   out_valid_q;

	always_comb begin
		cmd.capture = (state_q == S_IDLE) && req_valid;
		cmd.exec    = (state_q == S_EXEC);
		cmd.load    = (state_q == S_RESP) && (!out_valid_q || !rsp_stall);
	end

	assign req_stall = (state_q != S_IDLE);
	assign rsp_valid = out_valid_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_IDLE;
			out_valid_q <= 1'b0;
		end else begin
			unique case (state_q)
				S_IDLE: begin
					if (req_valid) state_q <= S_EXEC;
				end
				S_EXEC: state_q <= S_RESP;
				S_RESP: begin
					if (!out_valid_q || !rsp_stall) state_q <= S_IDLE;
				end
				default: state_q <= S_IDLE;
			endcase
			if (cmd.load) begin
				out_valid_q <= 1'b1;
			end else if (!rsp_stall) begin
				out_valid_q <= 1'b0;
			end
		end
	end

endmodule

[rtl/mlpq_dp.sv]
// datapath: entry memory, per-level pointers and counts, level select, result register
// depends on mlpq_pkg
module mlpq_dp import mlpq_pkg::*; #(
	parameter int NUM_LEVELS  = NUM_LEVELS_DEF,
	parameter int LEVEL_DEPTH = LEVEL_DEPTH_DEF,
	parameter int DATA_WIDTH  = DATA_WIDTH_DEF
) (
	input  logic clk,
	input  logic arst_n,
	input  cmd_t cmd,
	input  req_t req,
	output rsp_t rsp
);

	localparam int LW = $clog2(NUM_LEVELS);
	localparam int PW = (LEVEL_DEPTH > 1) ? $clog2(LEVEL_DEPTH) : 1;
	localparam int CW = $clog2(LEVEL_DEPTH + 1);
	localparam int ENTRIES = NUM_LEVELS * LEVEL_DEPTH;
	localparam int AW = $clog2(ENTRIES);

	req_t                  itm_q;
	logic [PW-1:0]         head_q  [NUM_LEVELS];
	logic [PW-1:0]         tail_q  [NUM_LEVELS];
	logic [CW-1:0]         count_q [NUM_LEVELS];
	logic [DATA_WIDTH-1:0] mem     [ENTRIES];
	logic [DATA_WIDTH-1:0] rd_q;
	status_t               status_q;
	logic [LW-1:0]         served_q;

	logic [NUM_LEVELS-1:0] nonempty;
	logic                  any_ne;
	logic [LW-1:0]         found;
	logic                  in_range;
	logic [LW-1:0]         enq_lvl;
	logic [LW-1:0]         lvl;
	logic                  enq_ok;
	logic                  deq_ok;
	logic [PW-1:0]         ptr;
	logic [PW-1:0]         ptr_nxt;
	logic [AW-1:0]         addr;

	// lowest-numbered non-empty level
	always_comb begin
		found = '0;
		for (int j = NUM_LEVELS - 1; j >= 0; j--) begin
			nonempty[j] = (count_q[j] != '0);
			if (nonempty[j]) found = LW'(j);
		end
		any_ne = |nonempty;
	end

	always_comb begin
		in_range = (32'(itm_q.priority_req) < 32'(NUM_LEVELS));
		enq_lvl  = LW'(itm_q.priority_req);
		lvl      = (itm_q.func == FUNC_DEQ) ? found : enq_lvl;
		enq_ok   = (itm_q.func == FUNC_ENQ) && in_range &&
		           (count_q[enq_lvl] < CW'(LEVEL_DEPTH));
		deq_ok   = (itm_q.func == FUNC_DEQ) && any_ne;
		ptr      = (itm_q.func == FUNC_DEQ) ? head_q[lvl] : tail_q[lvl];
		ptr_nxt  = (ptr == PW'(LEVEL_DEPTH - 1)) ? '0 : ptr + PW'(1);
		addr     = AW'(lvl) * AW'(LEVEL_DEPTH) + AW'(ptr);
	end

	always_ff @(posedge clk) begin
		if (cmd.capture) itm_q <= req;
	end

	always_ff @(posedge clk) begin
		if (cmd.exec && enq_ok) mem[addr] <= DATA_WIDTH'(itm_q.data_in);
		if (cmd.exec && deq_ok) rd_q <= mem[addr];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int j = 0; j < NUM_LEVELS; j++) begin
				head_q[j]  <= '0;
				tail_q[j]  <= '0;
				count_q[j] <= '0;
			end
		end else if (cmd.exec) begin
			if (enq_ok) begin
				tail_q[lvl]  <= ptr_nxt;
				count_q[lvl] <= count_q[lvl] + CW'(1);
			end else if (deq_ok) begin
				head_q[lvl]  <= ptr_nxt;
				count_q[lvl] <= count_q[lvl] - CW'(1);
			end
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.exec) begin
			priority if (itm_q.func == FUNC_ENQ) begin
				status_q <= enq_ok ? ST_ENQ_OK : ST_ENQ_DROP;
			end else begin
				status_q <= deq_ok ? ST_DEQ_OK : ST_DEQ_EMPTY;
			end
			served_q <= deq_ok ? lvl : '0;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.load) begin
			rsp.status       <= status_q;
			rsp.data_out     <= (status_q == ST_DEQ_OK) ? 32'(rd_q) : '0;
			rsp.served_level <= 3'(served_q);
		end
	end

endmodule

[tb/sv/testbench.sv]
// self-checking testbench for multi_level_priority_fifo
// depends on mlpq_pkg and the rtl of the block; keeps its own model of the level fifos
`timescale 1ns / 100ps

module testbench import mlpq_pkg::*;;

	localparam int IDLE_LIMIT   = 2000;
	localparam int DRAIN_CYCLES = 20;
	localparam int HOLD_CYCLES  = 300;

	typedef enum int {
		STALL_NONE,
		STALL_LIGHT,
		STALL_HEAVY,
		STALL_PERIODIC
	} stall_mode_t;

	logic clk;
	logic arst_n;
	logic req_valid;
	logic req_stall;
	req_t req;
	logic rsp_valid;
	logic rsp_stall;
	rsp_t rsp;

	// model of the queue state
	logic [31:0] lvl_word [NUM_LEVELS_DEF][LEVEL_DEPTH_DEF];
	int          lvl_head [NUM_LEVELS_DEF];
	int          lvl_tail [NUM_LEVELS_DEF];
	int          lvl_count[NUM_LEVELS_DEF];

	rsp_t rsp_due[$];
	int   fail_count;
	int   idle_cycles;
	int   burst_left;
	bit   sender_gaps;
	int   hold_request;

	multi_level_priority_fifo dut (
		.clk       (clk),
		.arst_n    (arst_n),
		.req_valid (req_valid),
		.req_stall (req_stall),
		.req       (req),
		.rsp_valid (rsp_valid),
		.rsp_stall (rsp_stall),
		.rsp       (rsp)
	);

	initial begin
		clk = 1'b0;
		forever #6 clk = ~clk;
	end

	// applies one request to the model and returns the response it gives
	function automatic rsp_t level_fifo_step(input req_t r);
		rsp_t o;
		int   lvl;
		bit   found;
		o     = '0;
		lvl   = r.priority_req;
		found = 1'b0;
		if (r.func == FUNC_ENQ) begin
			if (lvl >= NUM_LEVELS_DEF || lvl_count[lvl] >= LEVEL_DEPTH_DEF) begin
				o.status = ST_ENQ_DROP;
			end else begin
				lvl_word[lvl][lvl_tail[lvl]] = r.data_in;
				lvl_tail[lvl] = (lvl_tail[lvl] + 1) % LEVEL_DEPTH_DEF;
				lvl_count[lvl]++;
				o.status = ST_ENQ_OK;
			end
		end else begin
			o.status = ST_DEQ_EMPTY;
			for (int j = 0; j < NUM_LEVELS_DEF; j++) begin
				if (!found && lvl_count[j] != 0) begin
					found = 1'b1;
					o.data_out     = lvl_word[j][lvl_head[j]];
					o.served_level = j[2:0];
					o.status       = ST_DEQ_OK;
					lvl_head[j] = (lvl_head[j] + 1) % LEVEL_DEPTH_DEF;
					lvl_count[j]--;
				end
			end
		end
		return o;
	endfunction

	// offers one request, with bursts and random gaps, and waits for its transfer
	task automatic send_req(input logic f, input logic [2:0] lvl, input logic [31:0] word);
		req_t r;
		int   gap;
		r.func         = f;
		r.priority_req = lvl;
		r.data_in      = word;
		if (burst_left == 0) begin
			burst_left = $urandom_range(1, 24);
			gap = (!sender_gaps || $urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 8);
			if (gap > 0) begin
				req_valid <= 1'b0;
				req       <= {1'($urandom()), 3'($urandom()), 32'($urandom())};
				repeat (gap) @(posedge clk);
			end
		end
		burst_left--;
		req       <= r;
		req_valid <= 1'b1;
		@(posedge clk);
		while (req_stall) @(posedge clk);
	endtask

	// checker: predicts at each request transfer, compares at each response transfer
	always @(posedge clk) begin : rsp_checker
		rsp_t want;
		if (arst_n && req_valid && !req_stall)
			rsp_due.push_back(level_fifo_step(req));
		if (arst_n && rsp_valid && !rsp_stall) begin
			if (rsp_due.size() == 0) begin
				$error("unexpected response transfer: status %0d data_out %h served_level %0d",
					rsp.status, rsp.data_out, rsp.served_level);
				fail_count++;
			end else begin
				want = rsp_due.pop_front();
				if (rsp.status !== want.status) begin
					$error("status: expected %0d actual %0d", want.status, rsp.status);
					fail_count++;
				end
				if (rsp.data_out !== want.data_out) begin
					$error("data_out: expected %h actual %h", want.data_out, rsp.data_out);
					fail_count++;
				end
				if (rsp.served_level !== want.served_level) begin
					$error("served_level: expected %0d actual %0d",
						want.served_level, rsp.served_level);
					fail_count++;
				end
			end
		end
	end

	always @(posedge clk) begin
		if ((req_valid && !req_stall) || (rsp_valid && !rsp_stall)) begin
			idle_cycles <= 0;
		end else if (req_valid || rsp_due.size() != 0) begin
			idle_cycles <= idle_cycles + 1;
			if (idle_cycles >= IDLE_LIMIT) begin
				$display("tb: failure");
				$finish;
			end
		end
	end

	// receiver stall pattern, with a long hold on request
	initial begin : rsp_stall_gen
		stall_mode_t mode;
		int          run;
		int          hold_left;
		run       = 0;
		hold_left = 0;
		mode      = STALL_NONE;
		rsp_stall <= 1'b0;
		forever begin
			@(posedge clk);
			if (hold_left == 0 && hold_request != 0) begin
				hold_left    = hold_request;
				hold_request = 0;
			end
			if (hold_left > 0) begin
				hold_left--;
				rsp_stall <= 1'b1;
			end else begin
				if (run == 0) begin
					run  = $urandom_range(20, 300);
					mode = stall_mode_t'($urandom_range(0, 3));
				end
				run--;
				case (mode)
					STALL_NONE:     rsp_stall <= 1'b0;
					STALL_LIGHT:    rsp_stall <= ($urandom_range(0, 3) == 0);
					STALL_HEAVY:    rsp_stall <= ($urandom_range(0, 3) != 0);
					STALL_PERIODIC: rsp_stall <= (run % 5 < 2);
					default:        rsp_stall <= 1'b0;
				endcase
			end
		end
	end

	// dequeue with every level empty, ignored fields set
	task automatic test_all_empty;
		send_req(FUNC_DEQ, 3'd7, 32'hffff_ffff);
	endtask

	// fill the last level to the brim, then one more is dropped
	task automatic test_level_full;
		send_req(FUNC_ENQ, 3'd7, 32'h0000_0000);
		send_req(FUNC_ENQ, 3'd7, 32'hffff_ffff);
		for (int i = 0; i < 6; i++) send_req(FUNC_ENQ, 3'd7, $urandom());
		send_req(FUNC_ENQ, 3'd7, 32'h1234_5678);
	endtask

	// level 0 overtakes level 7, then tail of level 7 wraps
	task automatic test_priority_order;
		send_req(FUNC_ENQ, 3'd0, 32'hffff_ffff);
		send_req(FUNC_DEQ, 3'd5, 32'h0000_0000);
		send_req(FUNC_DEQ, 3'd0, $urandom());
		send_req(FUNC_ENQ, 3'd7, 32'h8000_0001);
	endtask

	// drain level 7 across the head wrap, then find it empty
	task automatic test_drain_wrap;
		for (int i = 0; i < 8; i++) send_req(FUNC_DEQ, 3'($urandom_range(0, 7)), $urandom());
		send_req(FUNC_DEQ, 3'd0, 32'h0000_0000);
	endtask

	// receiver holds off while the sender keeps offering
	task automatic test_backpressure;
		sender_gaps  = 1'b0;
		hold_request = HOLD_CYCLES;
		for (int i = 0; i < 48; i++) send_req(FUNC_ENQ, 3'($urandom_range(0, 7)), $urandom());
		hold_request = HOLD_CYCLES;
		for (int i = 0; i < 48; i++) send_req(FUNC_DEQ, 3'($urandom_range(0, 7)), $urandom());
		sender_gaps = 1'b1;
	endtask

	// random traffic in phases of changing enqueue share and level spread
	task automatic test_random_traffic(input int n_items);
		int          enq_pct;
		int          lo;
		int          hi;
		logic        f;
		logic [2:0]  lvl;
		logic [31:0] word;
		enq_pct = 50;
		lo      = 0;
		hi      = 7;
		for (int i = 0; i < n_items; i++) begin
			if (i % 100 == 0) begin
				enq_pct     = $urandom_range(15, 85);
				lo          = $urandom_range(0, 7);
				hi          = $urandom_range(lo, 7);
				sender_gaps = ($urandom_range(0, 3) != 0);
				if ($urandom_range(0, 2) == 0) begin
					lo = 0;
					hi = 7;
				end
			end
			f   = ($urandom_range(0, 99) < enq_pct) ? FUNC_ENQ : FUNC_DEQ;
			lvl = ($urandom_range(0, 9) == 0) ? 3'($urandom_range(0, 7)) :
			                                    3'($urandom_range(lo, hi));
			case ($urandom_range(0, 7))
				0:       word = 32'h0000_0000;
				1:       word = 32'hffff_ffff;
				default: word = $urandom();
			endcase
			send_req(f, lvl, word);
		end
	endtask

	initial begin
		fail_count   = 0;
		idle_cycles  = 0;
		burst_left   = 0;
		sender_gaps  = 1'b1;
		hold_request = 0;
		arst_n    <= 1'b0;
		req_valid <= 1'b0;
		req       <= '0;
		repeat (11) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		test_all_empty();
		test_level_full();
		test_priority_order();
		test_drain_wrap();
		test_random_traffic(700);
		test_backpressure();
		test_random_traffic(600);

		req_valid <= 1'b0;
		while (rsp_due.size() != 0) @(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);
		if (fail_count == 0)
			$display("tb: success");
		else
			$display("tb: failure");
		$finish;
	end

endmodule
